@@ design/kmst_pkg.sv @@
// ----------------------------------------------------------------------------
// kmst_pkg: shared types and constants
// Widths, defaults and the packed edge record used by the MST unit.
// ----------------------------------------------------------------------------
package kmst_pkg;
  localparam int MAX_NODES_DEF   = 32;
  localparam int MAX_EDGES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NODE_W          = 5;
  localparam int WT_W            = 16;
  localparam int TOT_W           = 21;
  localparam logic [TOT_W-1:0] TOTAL_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    logic [WT_W-1:0]   w;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);
endpackage

@@ design/kruskal_min_spanning_tree_unit.sv @@
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree_unit: streamed Kruskal MST engine
// Stores edges, sorts them by weight, then selects tree edges with
// union-find and emits each with a running total plus a summary.
// ----------------------------------------------------------------------------
// Edges are accepted one per cycle into an edge RAM until the request with
// last_edge set. Edges with an endpoint >= MAX_NODES are ignored; edges past
// MAX_EDGES are dropped and flagged in the summary. The run then finds, for
// each output rank, the next edge in (weight, arrival) order by a full scan
// of the edge RAM through one shared compare unit. Each edge then walks
// the parent table through one shared read port (root find, then path
// compression, each hop a read state and a wait state). The parent table
// is rebuilt as identity over all max(MAX_NODES, 32) slots at the start
// of each run. in_ready is low for the whole run; results wait in an
// output register until taken, and a new tree edge is not committed while
// that register is still full. Ties keep arrival order; total saturates
// at 2097151.
module kruskal_min_spanning_tree_unit
  import kmst_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int MAX_EDGES   = MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] in_edge_u,
  input  logic [NODE_W-1:0] in_edge_v,
  input  logic [WT_W-1:0]   in_edge_weight,
  input  logic              in_last_edge,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_u,
  output logic [NODE_W-1:0] out_v,
  output logic [WT_W-1:0]   out_weight,
  output logic [TOT_W-1:0]  out_running_total,
  output logic              out_is_summary,
  output logic              out_overflow,
  output logic              out_last_result
);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int SLOTS = (MAX_NODES > 32) ? MAX_NODES : 32;
  localparam int PA_W  = $clog2(SLOTS);

  typedef enum logic [3:0] {
    S_LOAD, S_PINIT, S_SCAN, S_SCANW, S_FIND, S_FINDW, S_COMP, S_COMPW,
    S_UNION, S_OUT, S_SUM
  } state_t;

  state_t state_r;
  logic [EC_W-1:0] count_r, rank_r, scan_r;
  logic ovf_r;
  logic [TOT_W-1:0] total_r;
  // best candidate for current rank; previous pick as lower bound
  logic [WT_W-1:0] best_w_r, prev_w_r;
  logic [EC_W-1:0] best_i_r, prev_i_r;
  logic            best_ok_r, have_prev_r;
  edge_t           best_e_r;
  // union-find walk
  logic [PA_W-1:0] x_r, r_r, ru_r, start_r;
  logic            side_r;   // 0 = u walk, 1 = v walk
  logic [PA_W-1:0] guard_r;
  logic            ovf_out_r;
  logic [$clog2(SLOTS+1)-1:0] init_r;

  // edge RAM
  logic          e_we;
  logic [EA_W-1:0] e_waddr, e_raddr;
  edge_t         e_wdata, e_rdata;
  kmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // parent RAM
  logic          p_we;
  logic [PA_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  kmst_ram #(.WIDTH(PA_W), .DEPTH(SLOTS)) u_par_ram (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  logic in_ok, accept;
  assign in_ready = (state_r == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign in_ok    = (int'(in_edge_u) < MAX_NODES) && (int'(in_edge_v) < MAX_NODES);

  logic [WT_W-1:0] wmask;
  assign wmask = (WEIGHT_BITS >= WT_W) ? {WT_W{1'b1}} : WT_W'((1 << WEIGHT_BITS) - 1);

  assign e_we    = accept && in_ok && (count_r < EC_W'(MAX_EDGES));
  assign e_waddr = count_r[EA_W-1:0];
  assign e_wdata = '{u: in_edge_u, v: in_edge_v, w: in_edge_weight & wmask};
  assign e_raddr = scan_r[EA_W-1:0];

  // shared compare: is (w,i) after previous pick and before current best
  logic [EC_W-1:0] cand_i;
  logic after_prev, before_best, take;
  assign cand_i      = scan_r - EC_W'(1);
  assign after_prev  = !have_prev_r || (e_rdata.w > prev_w_r) ||
                       (e_rdata.w == prev_w_r && cand_i > prev_i_r);
  assign before_best = !best_ok_r || (e_rdata.w < best_w_r);
  assign take        = after_prev && before_best;

  logic [TOT_W:0] sum_w;
  assign sum_w = {1'b0, total_r} + (TOT_W+1)'(best_e_r.w);

  logic [PA_W-1:0] node_u, node_v;
  assign node_u = PA_W'(best_e_r.u);
  assign node_v = PA_W'(best_e_r.v);

  always_comb begin
    p_we = 1'b0; p_waddr = x_r; p_wdata = r_r; p_raddr = x_r;
    unique case (state_r)
      S_PINIT: begin p_we = 1'b1; p_waddr = init_r[PA_W-1:0];
        p_wdata = init_r[PA_W-1:0]; end
      S_FIND:  p_raddr = r_r;
      S_COMP:  p_raddr = x_r;
      S_COMPW: begin p_we = (p_rdata != r_r) && (x_r != r_r); end
      S_UNION: begin p_we = (ru_r != r_r); p_waddr = r_r; p_wdata = ru_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; count_r <= '0; ovf_r <= 1'b0; out_valid <= 1'b0;
      total_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_LOAD: if (accept) begin
          if (in_ok && count_r < EC_W'(MAX_EDGES)) count_r <= count_r + EC_W'(1);
          else if (in_ok) ovf_r <= 1'b1;
          if (in_last_edge) begin
            ovf_out_r <= ovf_r || (in_ok && count_r >= EC_W'(MAX_EDGES));
            init_r <= '0; state_r <= S_PINIT;
          end
        end
        S_PINIT: begin
          init_r <= init_r + 1'b1;
          if (init_r == ($clog2(SLOTS+1))'(SLOTS - 1)) begin
            total_r <= '0; rank_r <= '0; have_prev_r <= 1'b0;
            scan_r <= '0; best_ok_r <= 1'b0;
            state_r <= (count_r == '0) ? S_SUM : S_SCAN;
          end
        end
        S_SCAN: begin scan_r <= scan_r + EC_W'(1); state_r <= S_SCANW; end
        S_SCANW: begin
          if (take) begin
            best_ok_r <= 1'b1; best_w_r <= e_rdata.w; best_i_r <= cand_i;
            best_e_r <= e_rdata;
          end
          if (scan_r == count_r) begin
            // rank chosen: walk u then v
            side_r <= 1'b0; state_r <= S_FIND; guard_r <= '0;
          end else begin
            scan_r <= scan_r + EC_W'(1);
          end
          if (scan_r == count_r) begin
            x_r <= take ? PA_W'(e_rdata.u) : node_u;
            r_r <= take ? PA_W'(e_rdata.u) : node_u;
            start_r <= take ? PA_W'(e_rdata.u) : node_u;
          end
        end
        S_FIND: state_r <= S_FINDW;
        S_FINDW: begin
          if (p_rdata == r_r || guard_r == PA_W'(SLOTS - 1)) begin
            x_r <= start_r; state_r <= S_COMP;
            if (p_rdata != r_r) r_r <= p_rdata;
          end else begin
            r_r <= p_rdata; guard_r <= guard_r + 1'b1; state_r <= S_FIND;
          end
        end
        S_COMP: state_r <= S_COMPW;
        S_COMPW: begin
          if ((p_rdata != r_r) && (x_r != r_r)) begin
            x_r <= p_rdata; state_r <= S_COMP;
          end else if (!side_r) begin
            ru_r <= r_r; side_r <= 1'b1; guard_r <= '0;
            x_r <= node_v; r_r <= node_v; start_r <= node_v; state_r <= S_FIND;
          end else begin
            state_r <= S_UNION;
          end
        end
        // hold here while an earlier result (e.g. last run's summary) waits
        S_UNION: if (!out_valid || out_ready) begin
          if (ru_r != r_r) begin
            total_r <= sum_w[TOT_W] ? TOTAL_MAX : sum_w[TOT_W-1:0];
            out_u <= best_e_r.u; out_v <= best_e_r.v; out_weight <= best_e_r.w;
            out_running_total <= sum_w[TOT_W] ? TOTAL_MAX : sum_w[TOT_W-1:0];
            out_is_summary <= 1'b0; out_overflow <= 1'b0; out_last_result <= 1'b0;
            out_valid <= 1'b1; state_r <= S_OUT;
          end else begin
            state_r <= S_OUT;
          end
          rank_r <= rank_r + EC_W'(1);
          have_prev_r <= 1'b1; prev_w_r <= best_w_r; prev_i_r <= best_i_r;
        end
        S_OUT: if (!out_valid || out_ready) begin
          scan_r <= '0; best_ok_r <= 1'b0;
          state_r <= (rank_r == count_r) ? S_SUM : S_SCAN;
        end
        S_SUM: if (!out_valid || out_ready) begin
          out_u <= '0; out_v <= '0; out_weight <= '0;
          out_running_total <= total_r; out_is_summary <= 1'b1;
          out_overflow <= ovf_out_r; out_last_result <= 1'b1; out_valid <= 1'b1;
          count_r <= '0; ovf_r <= 1'b0; state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

@@ design/kmst_ram.sv @@
// ----------------------------------------------------------------------------
// kmst_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/kmst_checker.sv @@
// ----------------------------------------------------------------------------
// kmst_checker: port-level checks for the MST unit
// Watches result framing and backpressure on the top-level ports.
// ----------------------------------------------------------------------------
module kmst_checker
  import kmst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [NODE_W-1:0] out_u,
  input logic [TOT_W-1:0] out_running_total,
  input logic out_is_summary,
  input logic out_overflow,
  input logic out_last_result
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_running_total))
    else $error("result dropped under backpressure");
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_summary == out_last_result))
    else $error("summary and last flags disagree");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_is_summary)
    else $error("overflow flag on an edge result");
  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_summary |-> out_u == '0)
    else $error("summary carries an endpoint");
endmodule

bind kruskal_min_spanning_tree_unit kmst_checker u_kmst_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_u, .out_running_total,
  .out_is_summary, .out_overflow, .out_last_result
);

@@ verif/kruskal_min_spanning_tree_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree_unit_test: self-checking bench for the MST unit
// Streams edge sets with random handshake pressure, predicts the selected
// tree edges and summary per set, and compares every result field by field.
// ----------------------------------------------------------------------------
module kruskal_min_spanning_tree_unit_test;
  import kmst_pkg::*;

  localparam int NODES  = MAX_NODES_DEF;
  localparam int EDGES  = MAX_EDGES_DEF;
  localparam int SLOTS  = 32;

  // one input request and one tree-edge / summary result
  typedef struct {
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    logic [WT_W-1:0]   w;
    logic              last;
  } edge_req_t;

  typedef struct {
    logic [NODE_W-1:0] u;
    logic [NODE_W-1:0] v;
    logic [WT_W-1:0]   w;
    logic [TOT_W-1:0]  total;
    logic              summary;
    logic              ovf;
    logic              last;
  } tree_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [NODE_W-1:0] in_edge_u = '0;
  logic [NODE_W-1:0] in_edge_v = '0;
  logic [WT_W-1:0]   in_edge_weight = '0;
  logic              in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NODE_W-1:0] out_u;
  logic [NODE_W-1:0] out_v;
  logic [WT_W-1:0]   out_weight;
  logic [TOT_W-1:0]  out_running_total;
  logic out_is_summary;
  logic out_overflow;
  logic out_last_result;

  kruskal_min_spanning_tree_unit DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // pending requests for the driver, expected results for the monitor
  edge_req_t edge_queue[$];
  tree_res_t tree_expect[$];
  int        mismatch_cnt = 0;

  // predictor state
  edge_req_t held_edges[EDGES];
  int        held_cnt = 0;
  bit        dropped = 1'b0;
  logic [NODE_W-1:0] parent[SLOTS];

  function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] nx;
    int guard;
    r = x;
    guard = 0;
    while (parent[r] != r && guard < SLOTS) begin
      r = parent[r];
      guard++;
    end
    // path compression
    while (parent[x] != r && x != r) begin
      nx = parent[x];
      parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  // Build the spanning forest for the held set; queue tree edges + summary.
  task automatic predict_tree();
    int order[EDGES];
    int i, j, cur, picked;
    logic [NODE_W-1:0] ru, rv;
    logic [21:0] sum;
    logic [TOT_W-1:0] total;
    tree_res_t r;
    // stable insertion sort on weight keeps arrival order for ties
    for (i = 0; i < held_cnt; i++) begin
      cur = i;
      j = i;
      while (j > 0 && held_edges[order[j-1]].w > held_edges[cur].w) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (i = 0; i < SLOTS; i++) parent[i] = i[NODE_W-1:0];
    total = '0;
    picked = 0;
    for (i = 0; i < held_cnt && picked < 31; i++) begin
      ru = find_root(held_edges[order[i]].u);
      rv = find_root(held_edges[order[i]].v);
      if (ru != rv) begin
        parent[rv] = ru;
        sum = {1'b0, total} + 22'(held_edges[order[i]].w);
        total = (sum > 22'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];
        r = '{held_edges[order[i]].u, held_edges[order[i]].v,
              held_edges[order[i]].w, total, 1'b0, 1'b0, 1'b0};
        tree_expect.push_back(r);
        picked++;
      end
    end
    r = '{'0, '0, '0, total, 1'b1, dropped, 1'b1};
    tree_expect.push_back(r);
    held_cnt = 0;
    dropped = 1'b0;
  endtask

  task automatic store_edge(edge_req_t e);
    // all 5-bit endpoints are in range with 32 nodes
    if (e.u < NODES && e.v < NODES) begin
      if (held_cnt < EDGES) begin
        held_edges[held_cnt] = e;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (e.last) predict_tree();
  endtask

  // ---- driver: bursts with random gaps ----
  int burst_left = 0;
  int gap_left = 0;
  edge_req_t cur_req;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        store_edge(cur_req);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (edge_queue.size() > 0) begin
          cur_req = edge_queue.pop_front();
          in_valid       <= 1'b1;
          in_edge_u      <= cur_req.u;
          in_edge_v      <= cur_req.v;
          in_edge_weight <= cur_req.w;
          in_last_edge   <= cur_req.last;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver stall pattern plus one long hold-off ----
  int hold_cycles = 0;
  int stall_phase = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && out_valid) begin
        // block sits on its output while the sender keeps offering
        long_hold_done <= 1'b1;
        hold_cycles <= 3000;
        out_ready <= 1'b0;
      end else if ((stall_phase / 64) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin
    tree_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (tree_expect.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: u=%0d v=%0d w=%0d total=%0d", out_u, out_v,
                   out_weight, out_running_total);
      end else begin
        exp_r = tree_expect.pop_front();
        if (out_u !== exp_r.u || out_v !== exp_r.v || out_weight !== exp_r.w ||
            out_running_total !== exp_r.total || out_is_summary !== exp_r.summary ||
            out_overflow !== exp_r.ovf || out_last_result !== exp_r.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp u=%0d v=%0d w=%0d tot=%0d sum=%0b ovf=%0b lst=%0b",
                     exp_r.u, exp_r.v, exp_r.w, exp_r.total, exp_r.summary,
                     exp_r.ovf, exp_r.last, "\n          got u=%0d v=%0d w=%0d ",
                     out_u, out_v, out_weight, "tot=%0d sum=%0b ovf=%0b lst=%0b",
                     out_running_total, out_is_summary, out_overflow,
                     out_last_result);
        end
      end
    end
  end

  function automatic edge_req_t mk_edge(int u, int v, int w, bit last);
    edge_req_t e;
    e.u = u[NODE_W-1:0];
    e.v = v[NODE_W-1:0];
    e.w = w[WT_W-1:0];
    e.last = last;
    return e;
  endfunction

  // ---- stimulus ----
  initial begin
    int i, set_len, nodes_span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single edge, self loop, extremes, tie ordering, cycle rejection
    edge_queue.push_back(mk_edge(0, 31, 65535, 1'b1));
    edge_queue.push_back(mk_edge(5, 5, 10, 1'b1));
    edge_queue.push_back(mk_edge(1, 2, 7, 1'b0));
    edge_queue.push_back(mk_edge(2, 3, 7, 1'b0));
    edge_queue.push_back(mk_edge(1, 3, 7, 1'b0));
    edge_queue.push_back(mk_edge(3, 4, 0, 1'b0));
    edge_queue.push_back(mk_edge(4, 4, 1, 1'b1));
    // heavy chain of max weights
    for (i = 0; i < 8; i++)
      edge_queue.push_back(mk_edge(i, i + 1, 65535, 1'b0));
    edge_queue.push_back(mk_edge(31, 30, 65535, 1'b1));
    // overflow: more than the store holds, last mark on a dropped edge
    for (i = 0; i < EDGES + 3; i++)
      edge_queue.push_back(mk_edge($urandom_range(0, 31), $urandom_range(0, 31),
                                   $urandom, i == EDGES + 2));

    // random sets: mostly small, some larger
    while (edge_queue.size() < 120) begin
      set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      nodes_span = $urandom_range(1, 31);
      for (i = 0; i < set_len; i++)
        edge_queue.push_back(mk_edge($urandom_range(0, nodes_span),
                                     $urandom_range(0, nodes_span),
                                     ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7)
                                                                 : $urandom,
                                     i == set_len - 1));
    end

    while (edge_queue.size() > 0 || in_valid) @(posedge clk);
    while (tree_expect.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
